/* hdl/go_to_point_steering_controller_defines.svh */
// Assertion macros for the go-to-point steering controller.
// Depends on nothing; included by the top level only.
`ifndef GO_TO_POINT_STEERING_CONTROLLER_DEFINES_SVH
`define GO_TO_POINT_STEERING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GTP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with the consequent delayed by dly, disabled while reset is held.
`define GTP_ASSERT_LAT(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

/* hdl/gtp_pkg.sv */
// Shared types, register codes and constants of the go-to-point steering controller.
// Depends on nothing; used by gtp_cordic, gtp_sqrt and the top level.
package gtp_pkg;

	// register codes, index = byte address / 4
	typedef enum logic [2:0] {
		REG_GOAL_X         = 3'd0,
		REG_GOAL_Y         = 3'd1,
		REG_HEADING_GAIN   = 3'd2,
		REG_TURN_THRESHOLD = 3'd3,
		REG_ARRIVAL_RADIUS = 3'd4
	} reg_idx_t;

	localparam logic [7:0]  GAIN_RESET      = 8'd64;
	localparam logic [15:0] THRESHOLD_RESET = 16'd819;
	localparam logic [15:0] RADIUS_RESET    = 16'd205;

	// CORDIC datapath: vector Q.8 (dx*256), angle Q.24 radians
	typedef logic signed [27:0] cvec_t;
	typedef logic signed [28:0] cang_t;

	localparam int    ATAN_ENTRIES = 24;
	localparam cang_t PI_Q24       = 29'sd52707179;

	localparam cang_t ATAN_Q24 [ATAN_ENTRIES] = '{
		29'sd13176795, 29'sd7778716, 29'sd4110060, 29'sd2086331,
		29'sd1047214,  29'sd524117,  29'sd262123,  29'sd131069,
		29'sd65536,    29'sd32768,   29'sd16384,   29'sd8192,
		29'sd4096,     29'sd2048,    29'sd1024,    29'sd512,
		29'sd256,      29'sd128,     29'sd64,      29'sd32,
		29'sd16,       29'sd8,       29'sd4,       29'sd2
	};

	// square root of a 34-bit sum of squares, one result bit per step
	localparam int SQ_W       = 34;
	localparam int SQRT_STEPS = SQ_W / 2;

	localparam logic signed [19:0] TURN_MAX = 20'sh7FFFF;
	localparam logic signed [19:0] TURN_MIN = 20'sh80000;

	// word carried alongside the CORDIC
	typedef struct packed {
		logic                    reached;
		logic signed [14:0]      heading;
		logic        [SQ_W-1:0]  sq;
	} cside_t;

	// word carried alongside the square root
	typedef struct packed {
		logic               reached;
		logic signed [19:0] rate;
		logic               gate;
	} rside_t;

endpackage

/* hdl/gtp_cordic.sv */
// Pipelined vectoring CORDIC: one micro-rotation per register stage.
// Depends on gtp_pkg (vector and angle types, arctangent table, side word).
module gtp_cordic #(
	parameter int STAGES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  gtp_pkg::cvec_t in_x,
	input  gtp_pkg::cvec_t in_y,
	input  gtp_pkg::cang_t in_z,
	input  gtp_pkg::cside_t in_side,
	output logic           out_valid,
	output gtp_pkg::cang_t out_z,
	output gtp_pkg::cside_t out_side
);

	logic            v_s    [STAGES+1];
	gtp_pkg::cvec_t  x_s    [STAGES+1];
	gtp_pkg::cvec_t  y_s    [STAGES+1];
	gtp_pkg::cang_t  z_s    [STAGES+1];
	gtp_pkg::cside_t side_s [STAGES+1];

	assign v_s[0]    = in_valid;
	assign x_s[0]    = in_x;
	assign y_s[0]    = in_y;
	assign z_s[0]    = in_z;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam gtp_pkg::cang_t ANG = gtp_pkg::ATAN_Q24[i];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		// rotate towards the x axis, accumulate the angle turned
		always_ff @(posedge clk) begin
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ANG;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ANG;
			end
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_valid = v_s[STAGES];
	assign out_z     = z_s[STAGES];
	assign out_side  = side_s[STAGES];

endmodule

/* hdl/gtp_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on gtp_pkg (widths, step count, side word).
module gtp_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [gtp_pkg::SQ_W-1:0] in_n,
	input  gtp_pkg::rside_t          in_side,
	output logic                     out_valid,
	output logic [gtp_pkg::SQ_W-1:0] out_root,
	output gtp_pkg::rside_t          out_side
);

	localparam int STEPS = gtp_pkg::SQRT_STEPS;
	localparam int W     = gtp_pkg::SQ_W;

	logic            v_s    [STEPS+1];
	logic [W-1:0]    rem_s  [STEPS+1];
	logic [W-1:0]    root_s [STEPS+1];
	gtp_pkg::rside_t side_s [STEPS+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = in_n;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [W-1:0] BIT = W'(1) << (2 * (STEPS - 1 - k));
		logic [W-1:0] trial;

		assign trial = root_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		// restoring step: keep the bit if the trial fits in the remainder
		always_ff @(posedge clk) begin
			if (rem_s[k] >= trial) begin
				rem_s[k+1]  <= rem_s[k] - trial;
				root_s[k+1] <= (root_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1]  <= rem_s[k];
				root_s[k+1] <= root_s[k] >> 1;
			end
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_root  = root_s[STEPS];
	assign out_side  = side_s[STEPS];

endmodule

/* hdl/go_to_point_steering_controller.sv */
// Go-to-point steering controller: proportional go-to-goal law, one pose per cycle.
// Depends on gtp_pkg, gtp_cordic, gtp_sqrt and go_to_point_steering_controller_defines.svh.
//
//   channel   | handshake                       | word
//   ----------+---------------------------------+------------------------------------------
//   pose in   | start & !busy                   | pose_x, pose_y, pose_heading
//   result    | done (one cycle, no back-press) | turn_rate, forward_speed, goal_reached
//   registers | psel & penable & pwrite (APB)   | paddr[4:2] selects, pwdata[15:0] / [7:0]
//
// The pipeline runs from the accepting edge to the done cycle through three front
// stages (offsets, squares, sum and pre-rotation), one stage per CORDIC
// micro-rotation, three turn-rate stages, seventeen square-root steps and the
// output register. A new pose is taken every cycle; busy is always low.
// Reset clears valid bits and restores the register defaults; the receiver cannot
// stall, so every stage advances each cycle and no word is held back.

`include "go_to_point_steering_controller_defines.svh"

module go_to_point_steering_controller #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// pose command
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [14:0] pose_heading,
	// result
	output logic               done,
	output logic signed [19:0] turn_rate,
	output logic        [15:0] forward_speed,
	output logic               goal_reached,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [4:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready
);

	localparam int SQ_W    = gtp_pkg::SQ_W;
	localparam int LATENCY = CORDIC_STAGES + gtp_pkg::SQRT_STEPS + 7;

	// ------------------------------------------------------------------
	// Register file
	// ------------------------------------------------------------------
	logic signed [15:0] goal_x_q;
	logic signed [15:0] goal_y_q;
	logic        [7:0]  heading_gain_q;
	logic        [15:0] turn_threshold_q;
	logic        [15:0] arrival_radius_q;
	logic               cfg_wr;
	gtp_pkg::reg_idx_t  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = gtp_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q         <= '0;
			goal_y_q         <= '0;
			heading_gain_q   <= gtp_pkg::GAIN_RESET;
			turn_threshold_q <= gtp_pkg::THRESHOLD_RESET;
			arrival_radius_q <= gtp_pkg::RADIUS_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				gtp_pkg::REG_GOAL_X:         goal_x_q         <= pwdata[15:0];
				gtp_pkg::REG_GOAL_Y:         goal_y_q         <= pwdata[15:0];
				gtp_pkg::REG_HEADING_GAIN:   heading_gain_q   <= pwdata[7:0];
				gtp_pkg::REG_TURN_THRESHOLD: turn_threshold_q <= pwdata[15:0];
				gtp_pkg::REG_ARRIVAL_RADIUS: arrival_radius_q <= pwdata[15:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			gtp_pkg::REG_GOAL_X:         prdata = 32'(unsigned'(goal_x_q));
			gtp_pkg::REG_GOAL_Y:         prdata = 32'(unsigned'(goal_y_q));
			gtp_pkg::REG_HEADING_GAIN:   prdata = 32'(heading_gain_q);
			gtp_pkg::REG_TURN_THRESHOLD: prdata = 32'(turn_threshold_q);
			gtp_pkg::REG_ARRIVAL_RADIUS: prdata = 32'(arrival_radius_q);
			default:                     prdata = '0;
		endcase
	end

	// Every stage advances each cycle, so a pose is always taken.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: offsets to the goal (exact, 17 bits)
	// ------------------------------------------------------------------
	logic               v_s1;
	logic signed [16:0] dx_s1;
	logic signed [16:0] dy_s1;
	logic signed [14:0] heading_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1      <= 17'(goal_x_q) - 17'(pose_x);
		dy_s1      <= 17'(goal_y_q) - 17'(pose_y);
		heading_s1 <= pose_heading;
	end

	// ------------------------------------------------------------------
	// Stage 2: squares of the offsets and of the arrival radius
	// ------------------------------------------------------------------
	logic               v_s2;
	logic signed [16:0] dx_s2;
	logic signed [16:0] dy_s2;
	logic signed [14:0] heading_s2;
	logic [SQ_W-1:0]    dxx_s2;
	logic [SQ_W-1:0]    dyy_s2;
	logic [31:0]        r2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dxx_s2     <= unsigned'(34'(dx_s1) * 34'(dx_s1));
		dyy_s2     <= unsigned'(34'(dy_s1) * 34'(dy_s1));
		r2_s2      <= 32'(arrival_radius_q) * 32'(arrival_radius_q);
		dx_s2      <= dx_s1;
		dy_s2      <= dy_s1;
		heading_s2 <= heading_s1;
	end

	// ------------------------------------------------------------------
	// Stage 3: sum of squares, arrival test, CORDIC pre-rotation
	// ------------------------------------------------------------------
	logic            v_s3;
	gtp_pkg::cvec_t  x_s3;
	gtp_pkg::cvec_t  y_s3;
	gtp_pkg::cang_t  z_s3;
	gtp_pkg::cside_t side_s3;
	logic [SQ_W-1:0] sq_sum;
	gtp_pkg::cvec_t  x_scaled;
	gtp_pkg::cvec_t  y_scaled;

	assign sq_sum   = dxx_s2 + dyy_s2;
	assign x_scaled = gtp_pkg::cvec_t'(signed'({dx_s2, 8'h00}));
	assign y_scaled = gtp_pkg::cvec_t'(signed'({dy_s2, 8'h00}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	// Left half-plane: negate the vector and start the angle at +pi or -pi.
	// Coincident points always count as arrived, so their angle never matters.
	always_ff @(posedge clk) begin
		if (dx_s2 < 0) begin
			x_s3 <= -x_scaled;
			y_s3 <= -y_scaled;
			z_s3 <= (dy_s2 >= 0) ? gtp_pkg::PI_Q24 : -gtp_pkg::PI_Q24;
		end else begin
			x_s3 <= x_scaled;
			y_s3 <= y_scaled;
			z_s3 <= '0;
		end
		side_s3.reached <= (sq_sum <= SQ_W'(r2_s2));
		side_s3.heading <= heading_s2;
		side_s3.sq      <= sq_sum;
	end

	// ------------------------------------------------------------------
	// CORDIC: bearing to the goal, Q.24 radians
	// ------------------------------------------------------------------
	logic            cv;
	gtp_pkg::cang_t  cz;
	gtp_pkg::cside_t cside;

	gtp_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_x      (x_s3),
		.in_y      (y_s3),
		.in_z      (z_s3),
		.in_side   (side_s3),
		.out_valid (cv),
		.out_z     (cz),
		.out_side  (cside)
	);

	// ------------------------------------------------------------------
	// Stage 4: heading error (no wrapping), Q.24
	// ------------------------------------------------------------------
	logic               v_s4;
	logic signed [29:0] diff_s4;
	gtp_pkg::cside_t    side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= cv;
		end
	end

	always_ff @(posedge clk) begin
		diff_s4 <= 30'(cz) - 30'(signed'({cside.heading, 12'h000}));
		side_s4 <= cside;
	end

	// ------------------------------------------------------------------
	// Stage 5: gain times error, Q.28
	// ------------------------------------------------------------------
	logic               v_s5;
	logic signed [38:0] prod_s5;
	gtp_pkg::cside_t    side_s5;
	logic signed [38:0] gain_ext;
	logic signed [38:0] diff_ext;

	assign gain_ext = 39'(signed'({1'b0, heading_gain_q}));
	assign diff_ext = 39'(diff_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s5 <= gain_ext * diff_ext;
		side_s5 <= side_s4;
	end

	// ------------------------------------------------------------------
	// Stage 6: round half up to Q.12, saturate, forward gate
	// ------------------------------------------------------------------
	logic               v_s6;
	gtp_pkg::rside_t    rside_s6;
	logic [SQ_W-1:0]    sq_s6;
	logic signed [39:0] rnd;
	logic signed [39:0] rate_wide;
	logic signed [19:0] rate_sat;
	logic        [20:0] rate_mag;

	assign rnd       = 40'(prod_s5) + 40'sd32768;
	assign rate_wide = rnd >>> 16;

	always_comb begin
		if (rate_wide > 40'(gtp_pkg::TURN_MAX)) begin
			rate_sat = gtp_pkg::TURN_MAX;
		end else if (rate_wide < 40'(gtp_pkg::TURN_MIN)) begin
			rate_sat = gtp_pkg::TURN_MIN;
		end else begin
			rate_sat = rate_wide[19:0];
		end
		rate_mag = rate_sat[19] ? unsigned'(-21'(rate_sat)) : unsigned'(21'(rate_sat));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		rside_s6.reached <= side_s5.reached;
		rside_s6.rate    <= rate_sat;
		rside_s6.gate    <= (rate_mag < 21'(turn_threshold_q));
		sq_s6            <= side_s5.sq;
	end

	// ------------------------------------------------------------------
	// Square root: distance in Q.11
	// ------------------------------------------------------------------
	logic            rv;
	logic [SQ_W-1:0] root;
	gtp_pkg::rside_t rside;

	gtp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_n      (sq_s6),
		.in_side   (rside_s6),
		.out_valid (rv),
		.out_root  (root),
		.out_side  (rside)
	);

	// ------------------------------------------------------------------
	// Output register: stop on arrival, hold speed at zero while turning
	// ------------------------------------------------------------------
	logic               done_q;
	logic signed [19:0] turn_rate_q;
	logic        [15:0] forward_speed_q;
	logic               goal_reached_q;
	logic        [15:0] speed_sat;

	assign speed_sat = (root > SQ_W'(16'hFFFF)) ? 16'hFFFF : root[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rv;
		end
	end

	always_ff @(posedge clk) begin
		if (rside.reached) begin
			turn_rate_q     <= '0;
			forward_speed_q <= '0;
			goal_reached_q  <= 1'b1;
		end else begin
			turn_rate_q     <= rside.rate;
			forward_speed_q <= rside.gate ? speed_sat : '0;
			goal_reached_q  <= 1'b0;
		end
	end

	assign done          = done_q;
	assign turn_rate     = turn_rate_q;
	assign forward_speed = forward_speed_q;
	assign goal_reached  = goal_reached_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`GTP_ASSERT_LAT(a_latency, clk, arst_n, start && !busy, LATENCY, done, "result strobe missing after pipeline latency")
	`GTP_ASSERT_IMP(a_arrived_stop, clk, arst_n, done && goal_reached, turn_rate == '0 && forward_speed == '0, "arrival must command a stop")
	`GTP_ASSERT_IMP(a_moving_gate, clk, arst_n, done && forward_speed != '0, !goal_reached && turn_rate != gtp_pkg::TURN_MIN && turn_threshold_q != '0, "forward motion while gated off")

endmodule
